[rtl/wsl3_pkg.sv]
// Shared types, constants and mix functions for the lookup3 word stream hash.
// Used by every module of the block; depends on nothing else.
package wsl3_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned COUNT_W     = 30;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [WORD_W-1:0] INIT_SEEDED   = 32'hdeadbeef;
  localparam logic [WORD_W-1:0] INIT_UNSEEDED = 32'hbe5eeded;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED     = 1'b0,
    CFG_UNSEEDED = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SLOT_A = 2'd0,
    SLOT_B = 2'd1,
    SLOT_C = 2'd2
  } slot_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
  } abc_t;

  typedef struct packed {
    logic  first;
    logic  empty;
    logic  last;
    slot_t slot;
  } tag_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    abc_t              init;
    tag_t              tag;
  } item_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input int unsigned k);
    return (x << k) | (x >> (WORD_W - k));
  endfunction

  function automatic abc_t abc_add(input abc_t x, input abc_t y);
    abc_t r;
    r.a = x.a + y.a;
    r.b = x.b + y.b;
    r.c = x.c + y.c;
    return r;
  endfunction

  // Word placed in the lane of its slot, zero in the others.
  function automatic abc_t slot_word(input slot_t slot, input logic [WORD_W-1:0] w);
    abc_t r;
    r = '0;
    priority if (slot == SLOT_A) begin
      r.a = w;
    end else if (slot == SLOT_B) begin
      r.b = w;
    end else begin
      r.c = w;
    end
    return r;
  endfunction

  function automatic abc_t mix_r12(input abc_t s);
    logic [WORD_W-1:0] a, b, c;
    a = s.a; b = s.b; c = s.c;
    a = a - c; a = a ^ rotl(c, 4);  c = c + b;
    b = b - a; b = b ^ rotl(a, 6);  a = a + c;
    return '{a: a, b: b, c: c};
  endfunction

  function automatic abc_t mix_r34(input abc_t s);
    logic [WORD_W-1:0] a, b, c;
    a = s.a; b = s.b; c = s.c;
    c = c - b; c = c ^ rotl(b, 8);  b = b + a;
    a = a - c; a = a ^ rotl(c, 16); c = c + b;
    return '{a: a, b: b, c: c};
  endfunction

  function automatic abc_t mix_r56(input abc_t s);
    logic [WORD_W-1:0] a, b, c;
    a = s.a; b = s.b; c = s.c;
    b = b - a; b = b ^ rotl(a, 19); a = a + c;
    c = c - b; c = c ^ rotl(b, 4);  b = b + a;
    return '{a: a, b: b, c: c};
  endfunction

  function automatic abc_t fin_s1(input abc_t s);
    logic [WORD_W-1:0] a, b, c;
    a = s.a; b = s.b; c = s.c;
    c = c ^ b; c = c - rotl(b, 14);
    a = a ^ c; a = a - rotl(c, 11);
    b = b ^ a; b = b - rotl(a, 25);
    return '{a: a, b: b, c: c};
  endfunction

  function automatic abc_t fin_s2(input abc_t s);
    logic [WORD_W-1:0] a, b, c;
    a = s.a; b = s.b; c = s.c;
    c = c ^ b; c = c - rotl(b, 16);
    a = a ^ c; a = a - rotl(c, 4);
    return '{a: a, b: b, c: c};
  endfunction

  function automatic logic [WORD_W-1:0] fin_s3(input abc_t s);
    logic [WORD_W-1:0] b, c;
    b = s.b; c = s.c;
    b = b ^ s.a; b = b - rotl(s.a, 14);
    c = c ^ b;   c = c - rotl(b, 24);
    return c;
  endfunction

endpackage

[rtl/word_stream_hash_lookup3_32.sv]
// Top level of the lookup3 word stream hash: front end, queue, back end, final mix.
// A result is valid once its last word has passed the queue and the final mix registers.
// Throughput: one word per cycle unless in_stall is high; a last word arriving within two
// words after a completed triple waits for the three-stage step mix; the queue absorbs it.
// Reset (rst_n low, synchronous) clears both registers, message state, queue and valids.
module word_stream_hash_lookup3_32 #(
  parameter int unsigned QUEUE_DEPTH = wsl3_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wsl3_pkg::WORD_W-1:0]    in_data_word,
  input  logic [wsl3_pkg::COUNT_W-1:0]   in_total_words,
  input  logic                           in_last_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wsl3_pkg::WORD_W-1:0]    out_hash_value,
  input  logic                           cfg_wr_en,
  input  logic [wsl3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wsl3_pkg::WORD_W-1:0]    cfg_wr_data
);

  wsl3_pkg::item_t push_item, pop_item;
  wsl3_pkg::abc_t  fin_state;
  logic            q_full, q_push, q_pop, q_valid;
  logic            fin_push, fin_raw, fin_ready;

  assign in_stall = q_full;

  wsl3_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_data_word   (in_data_word),
    .in_total_words (in_total_words),
    .in_last_word   (in_last_word),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (push_item)
  );

  wsl3_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (pop_item)
  );

  wsl3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .fin_ready (fin_ready),
    .fin_push  (fin_push),
    .fin_state (fin_state),
    .fin_raw   (fin_raw)
  );

  wsl3_final u_final (
    .clk            (clk),
    .rst_n          (rst_n),
    .fin_push       (fin_push),
    .fin_state      (fin_state),
    .fin_raw        (fin_raw),
    .fin_ready      (fin_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

endmodule

[rtl/wsl3_front.sv]
// Front end: configuration registers, input transfer and item classification.
// Tracks message position and computes the initial state; uses wsl3_pkg.
module wsl3_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [wsl3_pkg::WORD_W-1:0]         in_data_word,
  input  logic [wsl3_pkg::COUNT_W-1:0]        in_total_words,
  input  logic                                in_last_word,
  input  logic                                cfg_wr_en,
  input  logic [wsl3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wsl3_pkg::WORD_W-1:0]         cfg_wr_data,
  input  logic                                q_full,
  output logic                                q_push,
  output wsl3_pkg::item_t                     q_item
);

  logic [wsl3_pkg::WORD_W-1:0] seed_r, seed_nxt;
  logic                        unseeded_r, unseeded_nxt;
  logic                        in_msg_r, in_msg_nxt;
  wsl3_pkg::slot_t             slot_r, slot_nxt;
  wsl3_pkg::slot_t             slot_cur;
  logic [wsl3_pkg::WORD_W-1:0] seeded_v;

  always_comb begin
    seed_nxt     = seed_r;
    unseeded_nxt = unseeded_r;
    if (cfg_wr_en) begin
      unique case (wsl3_pkg::cfg_idx_t'(cfg_index))
        wsl3_pkg::CFG_SEED:     seed_nxt = cfg_wr_data;
        wsl3_pkg::CFG_UNSEEDED: unseeded_nxt = cfg_wr_data[0];
      endcase
    end
  end

  always_comb begin
    q_push   = in_valid && !q_full;
    slot_cur = in_msg_r ? slot_r : wsl3_pkg::SLOT_A;
    seeded_v = wsl3_pkg::INIT_SEEDED + {in_total_words, 2'b00} + seed_r;

    q_item.word      = in_data_word;
    q_item.tag.first = !in_msg_r;
    q_item.tag.empty = !in_msg_r && (in_total_words == '0);
    q_item.tag.last  = in_last_word;
    q_item.tag.slot  = slot_cur;
    if (unseeded_r) begin
      q_item.init.a = wsl3_pkg::INIT_UNSEEDED;
      q_item.init.b = {2'b00, in_total_words};
      q_item.init.c = '0;
    end else begin
      q_item.init.a = seeded_v;
      q_item.init.b = seeded_v;
      q_item.init.c = seeded_v;
    end

    in_msg_nxt = in_msg_r;
    slot_nxt   = slot_r;
    if (q_push && !q_item.tag.empty) begin
      if (in_last_word) begin
        in_msg_nxt = 1'b0;
        slot_nxt   = wsl3_pkg::SLOT_A;
      end else begin
        in_msg_nxt = 1'b1;
        priority if (slot_cur == wsl3_pkg::SLOT_A) begin
          slot_nxt = wsl3_pkg::SLOT_B;
        end else if (slot_cur == wsl3_pkg::SLOT_B) begin
          slot_nxt = wsl3_pkg::SLOT_C;
        end else begin
          slot_nxt = wsl3_pkg::SLOT_A;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= '0;
      unseeded_r <= 1'b0;
      in_msg_r   <= 1'b0;
      slot_r     <= wsl3_pkg::SLOT_A;
    end else begin
      seed_r     <= seed_nxt;
      unseeded_r <= unseeded_nxt;
      in_msg_r   <= in_msg_nxt;
      slot_r     <= slot_nxt;
    end
  end

endmodule

[rtl/wsl3_fifo.sv]
// Short queue of classified items between the front end and the back end.
// Holds wsl3_pkg::item_t entries; depth is set by the top level.
module wsl3_fifo #(
  parameter int unsigned DEPTH = wsl3_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wsl3_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output wsl3_pkg::item_t pop_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  wsl3_pkg::item_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  always_comb begin
    full      = (count_r == CNT_W'(DEPTH));
    not_empty = (count_r != '0);
    pop_item  = mem[rd_ptr_r];
    do_push   = push && !full;
    do_pop    = pop && not_empty;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/wsl3_back.sv]
// Back end: word accumulation and the three-stage step mix pipeline.
// Hands finished states to wsl3_final; uses wsl3_pkg types and functions.
module wsl3_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  wsl3_pkg::item_t q_item,
  output logic            q_pop,
  input  logic            fin_ready,
  output logic            fin_push,
  output wsl3_pkg::abc_t  fin_state,
  output logic            fin_raw
);

  wsl3_pkg::abc_t base_r, base_nxt;
  wsl3_pkg::abc_t pend_r, pend_nxt;
  wsl3_pkg::abc_t s1_r, s1_nxt;
  wsl3_pkg::abc_t s2_r, s2_nxt;
  logic           v1_r, v1_nxt;
  logic           v2_r, v2_nxt;

  wsl3_pkg::abc_t wadd, src, sum;
  logic           triple_end, needs_final, needs_state, go;

  always_comb begin
    triple_end  = !q_item.tag.last && !q_item.tag.empty &&
                  (q_item.tag.slot == wsl3_pkg::SLOT_C);
    needs_final = q_item.tag.empty || q_item.tag.last;
    needs_state = q_item.tag.first || q_item.tag.last || triple_end;
    go          = q_valid && !(needs_final && !fin_ready) &&
                  !(needs_state && (v1_r || v2_r));
    q_pop       = go;

    wadd = wsl3_pkg::slot_word(q_item.tag.slot, q_item.word);
    src  = q_item.tag.first ? q_item.init : wsl3_pkg::abc_add(base_r, pend_r);
    sum  = wsl3_pkg::abc_add(src, wadd);

    fin_push  = go && needs_final;
    fin_raw   = q_item.tag.empty;
    fin_state = q_item.tag.empty ? q_item.init : sum;

    v1_nxt = go && triple_end;
    s1_nxt = wsl3_pkg::mix_r12(sum);
    v2_nxt = v1_r;
    s2_nxt = wsl3_pkg::mix_r34(s1_r);

    base_nxt = base_r;
    if (v2_r) begin
      base_nxt = wsl3_pkg::mix_r56(s2_r);
    end else if (go && q_item.tag.first && !needs_final) begin
      base_nxt = q_item.init;
    end

    pend_nxt = pend_r;
    if (go && !needs_final) begin
      if (triple_end) begin
        pend_nxt = '0;
      end else if (q_item.tag.first) begin
        pend_nxt = wadd;
      end else begin
        pend_nxt = wsl3_pkg::abc_add(pend_r, wadd);
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    pend_r <= pend_nxt;
    s1_r   <= s1_nxt;
    s2_r   <= s2_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

endmodule

[rtl/wsl3_final.sv]
// Final mix pipeline and output register of the hash.
// Three mix stages behind an entry register; uses wsl3_pkg functions.
module wsl3_final (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fin_push,
  input  wsl3_pkg::abc_t              fin_state,
  input  logic                        fin_raw,
  output logic                        fin_ready,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wsl3_pkg::WORD_W-1:0] out_hash_value
);

  wsl3_pkg::abc_t              f0_r, f1_r, f2_r;
  logic [wsl3_pkg::WORD_W-1:0] f3_r;
  logic                        r0_r, r1_r, r2_r;
  logic                        v0_r, v1_r, v2_r, v3_r;
  logic                        en;

  assign en             = !(v3_r && out_stall);
  assign fin_ready      = en;
  assign out_valid      = v3_r;
  assign out_hash_value = f3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      f0_r <= fin_state;
      r0_r <= fin_raw;
      f1_r <= r0_r ? f0_r : wsl3_pkg::fin_s1(f0_r);
      r1_r <= r0_r;
      f2_r <= r1_r ? f1_r : wsl3_pkg::fin_s2(f1_r);
      r2_r <= r1_r;
      f3_r <= r2_r ? f2_r.c : wsl3_pkg::fin_s3(f2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= fin_push;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

endmodule

[rtl/wsl3_checker.sv]
// Port-level checker for the lookup3 word stream hash, bound to the top level.
// Sees only top-level ports; uses wsl3_pkg for the word width.
module wsl3_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [wsl3_pkg::WORD_W-1:0] out_hash_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Stalled result was dropped.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_hash_value))
    else $error("Stalled result changed.");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("Input stalled after reset.");

  a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("Queue filled without an input transfer.");

endmodule

bind word_stream_hash_lookup3_32 wsl3_checker u_wsl3_checker (.*);
